/* src/line_start_index_lookup_unit_assert.svh */
// ----------------------------------------------------------------------------
// Line start index lookup: assertion macros
// Shared concurrent assertion forms for the lookup unit's modules.
// ----------------------------------------------------------------------------
`ifndef LINE_START_INDEX_LOOKUP_UNIT_ASSERT_SVH
`define LINE_START_INDEX_LOOKUP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define LSIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsil assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define LSIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsil assertion failed");
`else
`define LSIL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSIL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/lsil_pkg.sv */
// ----------------------------------------------------------------------------
// Line start index lookup: package
// Field widths, request and status codes, defaults and shared types.
// ----------------------------------------------------------------------------
package lsil_pkg;

    localparam int MAX_LINES_DEF   = 1024;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;
    localparam int QOFF_W = 16;
    localparam int LINE_W = 10;
    localparam int COL_W  = 16;
    localparam int ST_W   = 2;

    // Working width for offset compares and column arithmetic.
    localparam int CALC_W = 32;

    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_OVFL  = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

    typedef struct packed {
        logic closed;
        logic overflowed;
        logic has_lines;
    } t_text_stat;

endpackage

/* src/lsil_ifs.sv */
// ----------------------------------------------------------------------------
// Line start index lookup: channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lsil_req_if;
    import lsil_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] text_byte;
    logic [QOFF_W-1:0] query_offset;

    modport source (output valid, req_type, text_byte, query_offset, input ready);
    modport sink   (input valid, req_type, text_byte, query_offset, output ready);
endinterface

interface lsil_rsp_if;
    import lsil_pkg::*;

    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column;
    logic [ST_W-1:0]   status;

    modport source (output valid, line_number, column, status, input ready);
    modport sink   (input valid, line_number, column, status, output ready);
endinterface

/* src/lsil_ram.sv */
// ----------------------------------------------------------------------------
// Line start index lookup: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/lsil_table.sv */
// ----------------------------------------------------------------------------
// Line start index lookup: line table builder
// Counts text bytes and writes each line start and the closing sentinel.
// ----------------------------------------------------------------------------
module lsil_table #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [lsil_pkg::REQ_W-1:0]   i_req_type,
    input  logic [lsil_pkg::BYTE_W-1:0]  i_text_byte,
    output lsil_pkg::t_text_stat         o_stat,
    output logic [$clog2(MAX_LINES)-1:0] o_hi_idx,
    output logic [OFFSET_BITS-1:0]       o_last_start,
    output logic                         o_we,
    output logic [$clog2(MAX_LINES)-1:0] o_waddr,
    output logic [OFFSET_BITS-1:0]       o_wdata
);
    import lsil_pkg::*;

    localparam int AW = $clog2(MAX_LINES);
    localparam int EW = $clog2(MAX_LINES + 1);

    logic [EW-1:0]          r_ec, n_ec;
    logic [OFFSET_BITS-1:0] r_bc, n_bc;
    logic                   r_closed, n_closed;
    logic                   r_ov, n_ov;
    logic [OFFSET_BITS-1:0] r_last, n_last;

    logic [EW-1:0]          ec0;
    logic [OFFSET_BITS-1:0] bc0;
    logic [OFFSET_BITS-1:0] bc_inc;
    logic                   ov0;
    logic [EW-1:0]          ec_m1;

    // A byte that arrives on closed text starts a new table; entry 0 is
    // always zero and is never stored.
    assign ec0    = r_closed ? EW'(1) : r_ec;
    assign bc0    = r_closed ? '0 : r_bc;
    assign ov0    = r_closed ? 1'b0 : r_ov;
    assign bc_inc = bc0 + OFFSET_BITS'(1);

    always_comb begin
        n_ec     = r_ec;
        n_bc     = r_bc;
        n_closed = r_closed;
        n_ov     = r_ov;
        n_last   = r_last;
        o_we     = 1'b0;
        o_waddr  = r_ec[AW-1:0];
        o_wdata  = r_bc;
        if (i_take) begin
            unique case (i_req_type)
                REQ_BYTE: begin
                    n_closed = 1'b0;
                    n_ec     = ec0;
                    n_bc     = bc0;
                    n_ov     = ov0;
                    if (&bc0) begin
                        n_ov = 1'b1;
                    end else begin
                        n_bc = bc_inc;
                        if (i_text_byte == NEWLINE) begin
                            if (ec0 < EW'(MAX_LINES - 1)) begin
                                o_we    = 1'b1;
                                o_waddr = ec0[AW-1:0];
                                o_wdata = bc_inc;
                                n_ec    = ec0 + EW'(1);
                            end else begin
                                n_ov = 1'b1;
                            end
                        end
                    end
                end
                REQ_END: begin
                    if (!r_closed) begin
                        if (r_ec < EW'(MAX_LINES)) begin
                            o_we = 1'b1;
                            n_ec = r_ec + EW'(1);
                        end
                        n_closed = 1'b1;
                        n_last   = r_bc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec     <= '0;
            r_bc     <= '0;
            r_closed <= 1'b1;
            r_ov     <= 1'b0;
        end else begin
            r_ec     <= n_ec;
            r_bc     <= n_bc;
            r_closed <= n_closed;
            r_ov     <= n_ov;
        end
        r_last <= n_last;
    end

    assign ec_m1             = r_ec - EW'(1);
    assign o_hi_idx          = ec_m1[AW-1:0];
    assign o_last_start      = r_last;
    assign o_stat.closed     = r_closed;
    assign o_stat.overflowed = r_ov;
    assign o_stat.has_lines  = (r_ec >= EW'(2));

    `include "line_start_index_lookup_unit_assert.svh"

    `LSIL_ASSERT_IMP(a_ec_bound, i_clk, i_rst_n, 1'b1, r_ec <= EW'(MAX_LINES))
    `LSIL_ASSERT_IMP(a_open_has_start, i_clk, i_rst_n, !r_closed, r_ec >= EW'(1))
    `LSIL_ASSERT_NXT(a_byte_opens, i_clk, i_rst_n, i_take && i_req_type == REQ_BYTE, !r_closed)
endmodule

/* src/lsil_search.sv */
// ----------------------------------------------------------------------------
// Line start index lookup: search sequencer
// Binary search over the line table.
// ----------------------------------------------------------------------------
module lsil_search #(
    parameter int MAX_LINES   = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsil_pkg::QOFF_W-1:0]  i_query_offset,
    input  lsil_pkg::t_text_stat         i_stat,
    input  logic [$clog2(MAX_LINES)-1:0] i_hi_idx,
    input  logic [OFFSET_BITS-1:0]       i_last_start,
    output logic                         o_busy,
    output logic [$clog2(MAX_LINES)-1:0] o_raddr,
    input  logic [OFFSET_BITS-1:0]       i_rdata,
    lsil_rsp_if.source                   o_rsp
);
    import lsil_pkg::*;

    localparam int AW = $clog2(MAX_LINES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [AW-1:0]          r_lo, n_lo;
    logic [AW-1:0]          r_hi, n_hi;
    logic [AW-1:0]          r_mid, n_mid;
    logic [OFFSET_BITS-1:0] r_lo_start, n_lo_start;
    logic [QOFF_W-1:0]      r_off, n_off;
    logic [ST_W-1:0]        r_st, n_st;
    logic                   r_out_valid, n_out_valid;
    logic [LINE_W-1:0]      r_line, n_line;
    logic [COL_W-1:0]       r_col, n_col;
    logic [ST_W-1:0]        r_out_st, n_out_st;

    logic [AW-1:0]     span;
    logic [AW-1:0]     mid;
    logic [CALC_W-1:0] off_x;
    logic [CALC_W-1:0] rdata_x;
    logic [CALC_W-1:0] diff;
    logic [CALC_W-1:0] lo_x;
    logic              out_free;

    assign span     = r_hi - r_lo;
    assign mid      = r_lo + (span >> 1);
    assign off_x    = CALC_W'(r_off);
    assign rdata_x  = CALC_W'(i_rdata);
    assign diff     = off_x - CALC_W'(r_lo_start);
    assign lo_x     = CALC_W'(r_lo);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign o_raddr  = mid;

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_lo_start  = r_lo_start;
        n_off       = r_off;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_line      = r_line;
        n_col       = r_col;
        n_out_st    = r_out_st;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_off      = i_query_offset;
                    n_lo       = '0;
                    n_hi       = '0;
                    n_lo_start = '0;
                    n_state    = S_STEP;
                    if (!i_stat.closed || !i_stat.has_lines) begin
                        n_st = ST_RANGE;
                    end else if (i_stat.overflowed) begin
                        n_st = ST_OVFL;
                    end else if (CALC_W'(i_query_offset) >= CALC_W'(i_last_start)) begin
                        n_st = ST_RANGE;
                    end else begin
                        n_st = ST_OK;
                        n_hi = i_hi_idx;
                    end
                end
            end
            S_STEP: begin
                if (span > AW'(1)) begin
                    n_mid   = mid;
                    n_state = S_CMP;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_st;
                    n_line      = (r_st == ST_OK) ? lo_x[LINE_W-1:0] : '0;
                    n_col       = (r_st == ST_OK) ? diff[COL_W-1:0] : '0;
                    n_state     = S_IDLE;
                end
            end
            S_CMP: begin
                // Read data for the midpoint arrives in the cycle after the address is presented.
                if (rdata_x <= off_x) begin
                    n_lo       = r_mid;
                    n_lo_start = i_rdata;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_STEP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_lo_start <= n_lo_start;
        r_off      <= n_off;
        r_st       <= n_st;
        r_line     <= n_line;
        r_col      <= n_col;
        r_out_st   <= n_out_st;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.line_number = r_line;
    assign o_rsp.column      = r_col;
    assign o_rsp.status      = r_out_st;

    `include "line_start_index_lookup_unit_assert.svh"

    `LSIL_ASSERT_IMP(a_mid_inside, i_clk, i_rst_n, r_state == S_CMP,
        r_lo < r_mid && r_mid < r_hi)
    `LSIL_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, r_out_valid && r_out_st != ST_OK,
        r_line == '0 && r_col == '0)
    `LSIL_ASSERT_NXT(a_finish_loads, i_clk, i_rst_n,
        r_state == S_STEP && span <= AW'(1) && out_free, r_out_valid && r_state == S_IDLE)
endmodule

/* src/line_start_index_lookup_unit.sv */
// ----------------------------------------------------------------------------
// Line start index lookup unit
// Builds a table of line starts from streamed text and answers
// offset-to-line/column queries by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transfer: a text byte, an end-of-text mark
//   or a position query. o_rsp carries one result per query; bytes and
//   end-of-text marks produce no result.
//   Text streams in at one transfer per cycle while no query is in
//   progress; i_req is not ready while a query is busy.
//   A query's result is loaded into the output register after S halving
//   steps, and i_req is ready again once the result is loaded, so a query
//   holds the input until then. S is at most ceil(log2(L)) halving steps for
//   L lines, and zero for a query that fails; each step is one read of the
//   line table RAM and one compare of the entry read with the query offset.
//   A query whose result cannot be loaded because o_rsp is stalled waits in
//   its final state; bytes are taken again as soon as the result is loaded.
//   Reset returns the unit to closed text with no lines; the first byte
//   after reset (or after an end-of-text mark) starts a new table. The line
//   table RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module line_start_index_lookup_unit #(
    parameter int MAX_LINES   = lsil_pkg::MAX_LINES_DEF,
    parameter int OFFSET_BITS = lsil_pkg::OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsil_req_if.sink   i_req,
    lsil_rsp_if.source o_rsp
);
    import lsil_pkg::*;

    localparam int AW = $clog2(MAX_LINES);

    logic                   busy;
    logic                   accept;
    logic                   take;
    logic                   start;
    t_text_stat             stat;
    logic [AW-1:0]          hi_idx;
    logic [OFFSET_BITS-1:0] last_start;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [OFFSET_BITS-1:0] wdata;
    logic [AW-1:0]          raddr;
    logic [OFFSET_BITS-1:0] rdata;

    assign i_req.ready = !busy;
    assign accept      = i_req.valid && !busy;
    assign start       = accept && (i_req.req_type == REQ_QUERY);
    assign take        = accept && (i_req.req_type != REQ_QUERY);

    lsil_table #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_req_type   (i_req.req_type),
        .i_text_byte  (i_req.text_byte),
        .o_stat       (stat),
        .o_hi_idx     (hi_idx),
        .o_last_start (last_start),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    lsil_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (MAX_LINES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lsil_search #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_query_offset (i_req.query_offset),
        .i_stat         (stat),
        .i_hi_idx       (hi_idx),
        .i_last_start   (last_start),
        .o_busy         (busy),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_rsp          (o_rsp)
    );
endmodule
